>>> src/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and codes for the LRU key cache
// Transaction payloads, result status codes and the per-cell command group.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned SlotW = 7;

  localparam logic FuncLookup = 1'b0;
  localparam logic FuncFlush  = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_INSERT = 3'd1,
    ST_EVICT  = 3'd2,
    ST_FAIL   = 3'd3,
    ST_FLUSH  = 3'd4
  } status_e;

  typedef struct packed {
    logic            func;
    logic [KeyW-1:0] key;
    logic            create_ok;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [SlotW-1:0] slot;
    logic [KeyW-1:0]  evicted_key;
  } out_t;

  typedef struct packed {
    logic capture;
    logic flush;
    logic touch;
    logic insert;
    logic evict;
  } cell_cmd_t;

endpackage

>>> src/lkc_cell.sv
// ----------------------------------------------------------------------------
// lkc_cell: one cache entry
// Holds valid, key and recency rank; compares the probe key, flags the oldest
// entry and passes the first-free-slot carry to its neighbor.
// ----------------------------------------------------------------------------
module lkc_cell #(
  parameter int unsigned CAPACITY = 128,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lkc_pkg::cell_cmd_t            cmd_i,
  input  logic [KEY_BITS-1:0]           key_i,
  input  logic [$clog2(CAPACITY)-1:0]   hit_rank_i,
  input  logic                          taken_i,
  output logic                          taken_o,
  output logic                          valid_o,
  output logic                          hit_o,
  output logic                          victim_o,
  output logic                          free_o,
  output logic [KEY_BITS-1:0]           key_o,
  output logic [$clog2(CAPACITY)-1:0]   rank_o
);

  localparam int unsigned RankW = $clog2(CAPACITY);
  localparam logic [RankW-1:0] LastRank = RankW'(CAPACITY - 1);

  logic             valid_q;
  logic             hit_q;
  logic             victim_q;
  logic [KEY_BITS-1:0] key_q;
  logic [RankW-1:0] rank_q;
  logic             free_sel;

  assign free_sel = !valid_q && !taken_i;
  assign taken_o  = taken_i || !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      hit_q    <= 1'b0;
      victim_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        hit_q    <= valid_q && (key_q == key_i);
        victim_q <= valid_q && (rank_q == LastRank);
      end
      if (cmd_i.flush) begin
        valid_q <= 1'b0;
      end else if (cmd_i.insert && free_sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.touch) begin
      if (hit_q) begin
        rank_q <= '0;
      end else if (valid_q && (rank_q < hit_rank_i)) begin
        rank_q <= rank_q + RankW'(1);
      end
    end else if (cmd_i.insert) begin
      if (free_sel) begin
        key_q  <= key_i;
        rank_q <= '0;
      end else if (valid_q) begin
        rank_q <= rank_q + RankW'(1);
      end
    end else if (cmd_i.evict) begin
      if (victim_q) begin
        key_q  <= key_i;
        rank_q <= '0;
      end else if (valid_q) begin
        rank_q <= rank_q + RankW'(1);
      end
    end
  end

  assign valid_o  = valid_q;
  assign hit_o    = hit_q;
  assign victim_o = victim_q;
  assign free_o   = free_sel;
  assign key_o    = key_q;
  assign rank_o   = rank_q;

endmodule

>>> src/lkc_sel.sv
// ----------------------------------------------------------------------------
// lkc_sel: slot encoder for the cell row
// Encodes the hit, victim and free one-hot vectors into slot numbers and
// gathers the hit rank and the victim key.
// ----------------------------------------------------------------------------
module lkc_sel #(
  parameter int unsigned CAPACITY = 128,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic [CAPACITY-1:0]                        hit_i,
  input  logic [CAPACITY-1:0]                        victim_i,
  input  logic [CAPACITY-1:0]                        free_i,
  input  logic [CAPACITY-1:0][$clog2(CAPACITY)-1:0]  rank_i,
  input  logic [CAPACITY-1:0][KEY_BITS-1:0]          key_i,
  output logic                                       hit_any_o,
  output logic [$clog2(CAPACITY)-1:0]                hit_idx_o,
  output logic [$clog2(CAPACITY)-1:0]                hit_rank_o,
  output logic [$clog2(CAPACITY)-1:0]                victim_idx_o,
  output logic [KEY_BITS-1:0]                        victim_key_o,
  output logic [$clog2(CAPACITY)-1:0]                free_idx_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);

  always_comb begin
    hit_idx_o    = '0;
    hit_rank_o   = '0;
    victim_idx_o = '0;
    victim_key_o = '0;
    free_idx_o   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_idx_o    |= {IdxW{hit_i[i]}} & IdxW'(i);
      hit_rank_o   |= {IdxW{hit_i[i]}} & rank_i[i];
      victim_idx_o |= {IdxW{victim_i[i]}} & IdxW'(i);
      victim_key_o |= {KEY_BITS{victim_i[i]}} & key_i[i];
      free_idx_o   |= {IdxW{free_i[i]}} & IdxW'(i);
    end
  end

  assign hit_any_o = |hit_i;

endmodule

>>> src/lru_key_cache.sv
// ----------------------------------------------------------------------------
// lru_key_cache: fully associative key cache with LRU replacement
// Row of entry cells with parallel compare, a slot encoder and a controller.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request per transaction: a lookup/insert
//   with a key and a create_ok flag, or a flush. The output channel returns
//   exactly one result per request: status, slot and evicted key.
//   Every cell compares the incoming key in the accept cycle and registers
//   its hit and oldest-entry flags. In the update state, once the output
//   register is free, the slot encoder picks the hit, victim or first free
//   slot, all cells update their recency ranks in parallel and the result
//   is loaded into the output register. One request is in flight at a
//   time: no new request is taken until the current one has passed the
//   compare step and the update step across the cell row.
//   When the receiver stalls with a result still held, the update waits
//   until the output register frees and in_ready_o stays low.
//   Reset empties the cache and clears the output register; it takes effect
//   at once, with no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_cache #(
  parameter int unsigned CAPACITY = 128,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lkc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lkc_pkg::out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned KeyW = lkc_pkg::KeyW;
  localparam int unsigned SlotW = lkc_pkg::SlotW;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_e;

  state_e             state_q;
  lkc_pkg::in_t       req_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               out_valid_q;
  lkc_pkg::out_t      out_data_q, res_d;
  logic               in_fire;
  logic               out_free;
  logic               commit;
  logic               full;
  lkc_pkg::cell_cmd_t cmd;
  logic [KEY_BITS-1:0] probe_key;

  logic [CAPACITY:0]                 taken;
  logic [CAPACITY-1:0]               valid_vec;
  logic [CAPACITY-1:0]               hit_vec;
  logic [CAPACITY-1:0]               victim_vec;
  logic [CAPACITY-1:0]               free_vec;
  logic [CAPACITY-1:0][IdxW-1:0]     rank_vec;
  logic [CAPACITY-1:0][KEY_BITS-1:0] key_vec;

  logic                hit_any;
  logic [IdxW-1:0]     hit_idx, hit_rank, victim_idx, free_idx;
  logic [KEY_BITS-1:0] victim_key;
  logic [IdxW+SlotW-1:0] hit_slot_ext, victim_slot_ext, free_slot_ext;
  logic [KEY_BITS+KeyW-1:0] victim_key_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == S_UPD) && out_free;
  assign full       = (count_q == CntW'(CAPACITY));
  assign probe_key  = (state_q == S_IDLE) ? in_data_i.key[KEY_BITS-1:0]
                                          : req_q.key[KEY_BITS-1:0];

  assign taken[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lkc_cell #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .key_i     (probe_key),
      .hit_rank_i(hit_rank),
      .taken_i   (taken[g]),
      .taken_o   (taken[g+1]),
      .valid_o   (valid_vec[g]),
      .hit_o     (hit_vec[g]),
      .victim_o  (victim_vec[g]),
      .free_o    (free_vec[g]),
      .key_o     (key_vec[g]),
      .rank_o    (rank_vec[g])
    );
  end

  lkc_sel #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) u_sel (
    .hit_i       (hit_vec),
    .victim_i    (victim_vec),
    .free_i      (free_vec),
    .rank_i      (rank_vec),
    .key_i       (key_vec),
    .hit_any_o   (hit_any),
    .hit_idx_o   (hit_idx),
    .hit_rank_o  (hit_rank),
    .victim_idx_o(victim_idx),
    .victim_key_o(victim_key),
    .free_idx_o  (free_idx)
  );

  assign hit_slot_ext    = {{SlotW{1'b0}}, hit_idx};
  assign victim_slot_ext = {{SlotW{1'b0}}, victim_idx};
  assign free_slot_ext   = {{SlotW{1'b0}}, free_idx};
  assign victim_key_ext  = {{KeyW{1'b0}}, victim_key};

  always_comb begin
    cmd         = '0;
    cmd.capture = in_fire;
    res_d       = '0;
    count_d     = count_q;
    if (commit) begin
      priority if (req_q.func == lkc_pkg::FuncFlush) begin
        cmd.flush    = 1'b1;
        res_d.status = lkc_pkg::ST_FLUSH;
        count_d      = '0;
      end else if (hit_any) begin
        cmd.touch    = 1'b1;
        res_d.status = lkc_pkg::ST_HIT;
        res_d.slot   = hit_slot_ext[SlotW-1:0];
      end else if (!req_q.create_ok) begin
        res_d.status = lkc_pkg::ST_FAIL;
      end else if (full) begin
        cmd.evict         = 1'b1;
        res_d.status      = lkc_pkg::ST_EVICT;
        res_d.slot        = victim_slot_ext[SlotW-1:0];
        res_d.evicted_key = victim_key_ext[KeyW-1:0];
      end else begin
        cmd.insert   = 1'b1;
        res_d.status = lkc_pkg::ST_INSERT;
        res_d.slot   = free_slot_ext[SlotW-1:0];
        count_d      = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            req_q   <= in_data_i;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (commit) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_d;
            count_q     <= count_d;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_hit_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(hit_vec))
    else $error("more than one cell hit");

  a_victim_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && full) |-> $onehot(victim_vec))
    else $error("full cache without a single oldest entry");

  a_free_when_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !full) |-> $onehot(free_vec))
    else $error("no single free slot while not full");

  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(valid_vec) == 32'(count_q)))
    else $error("entry count disagrees with valid cells");

  a_commit_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_valid_q && state_q == S_IDLE))
    else $error("update did not produce a result");

endmodule
